FILE: rtl/core/sctl_pkg.sv
// shared constants and types of the sensor curve temperature lookup unit
package sctl_pkg;

  // curve storage and fixed-point format
  localparam int CURVE_DEPTH = 64;
  localparam int FRAC_BITS   = 5;

  localparam int ADDR_W = $clog2(CURVE_DEPTH);
  localparam int CNT_W  = $clog2(CURVE_DEPTH + 1);

  // field widths
  localparam int IDX_W   = 6;
  localparam int VAL_W   = 16;
  localparam int TEMP_W  = 24;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // output saturation bounds
  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  // input word kinds
  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_MIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_MAX      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DEGREES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FALLING_CURVE = 3'd4;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FETCH = 6'b000010,
    ST_CMP   = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

endpackage

FILE: rtl/core/sensor_curve_temperature_lookup_unit.sv
// top level of the sensor curve temperature lookup unit
//
// Converts a raw sensor reading into a signed 24 bit temperature with
// FRAC_BITS fractional bits by piecewise linear interpolation over a
// calibration curve that software loads word by word (tuser high, entry
// index and value in tdata). A conversion scans the curve through the
// single read port of the curve memory, one entry per cycle; on a match it
// runs, unless the span is zero, a restoring divider that yields one
// quotient bit per cycle (16 + FRAC_BITS steps), then one multiply and one
// saturating subtract. A reading beyond the curve (length clipped to the
// table depth) skips the divider and the multiply. The result waits in
// ST_FIN until the output register is free.
// The input side is not ready while a conversion runs; a finished result
// waits in an output register so the next word can be taken meanwhile.
// Curve entries that are read must have been written first; they hold no
// reset value.
module sensor_curve_temperature_lookup_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sctl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sctl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // entry_index [5:0], entry_value [21:6], reading [37:22], zero fill
  input  logic [sctl_pkg::S_DATA_W-1:0]     s_axis_tdata_i,
  // op [0]
  input  logic                              s_axis_tuser_i,
  // result stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // temperature [23:0]
  output logic [sctl_pkg::M_DATA_W-1:0]     m_axis_tdata_o,
  // beyond_curve [0], zero_divisor [1]
  output logic [1:0]                        m_axis_tuser_o
);
  import sctl_pkg::*;

  // divider dividend and quotient width, step counter, base, product and sum widths
  localparam int NW   = VAL_W + FRAC_BITS;
  localparam int DCW  = $clog2(NW);
  localparam int BW   = 10 + CNT_W;
  localparam int PW   = NW + 10;
  localparam int TW   = NW + 12;

  localparam logic signed [TW-1:0] SAT_HI = TW'(OUT_MAX);
  localparam logic signed [TW-1:0] SAT_LO = TW'(OUT_MIN);

  // configuration registers
  logic signed [9:0] temp_min_q;
  logic signed [9:0] temp_max_q;
  logic [7:0]        step_q;
  logic [6:0]        curve_len_q;
  logic              falling_q;

  // sequencer
  state_e           state_q, state_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [CNT_W-1:0] i_nxt;
  logic [CNT_W-1:0] len_c;
  logic [DCW-1:0]   cnt_q, cnt_d;

  // datapath registers
  logic [VAL_W-1:0]       reading_q;
  logic [VAL_W-1:0]       prev_q;
  logic signed [BW-1:0]   base_q;
  logic [VAL_W-1:0]       rem_q;
  logic [NW-1:0]          quo_q;
  logic [VAL_W-1:0]       div_q;
  logic                   den_neg_q;
  logic                   zero_q;
  logic                   beyond_q;
  logic signed [PW-1:0]   prod_q;

  // output register
  logic                   out_valid_q;
  logic [TEMP_W-1:0]      out_temp_q;
  logic                   out_beyond_q;
  logic                   out_zero_q;

  // curve memory
  logic [VAL_W-1:0]  curve_mem [CURVE_DEPTH];
  logic [VAL_W-1:0]  rd_data_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;

  // input fields
  logic [IDX_W-1:0] in_index;
  logic [VAL_W-1:0] in_value;
  logic [VAL_W-1:0] in_reading;
  logic             s_fire;
  logic             cfg_fire;
  logic             out_free;

  // compare and interpolation terms
  logic [VAL_W-1:0]     cur;
  logic [VAL_W-1:0]     prev_eff;
  logic                 match;
  logic [VAL_W-1:0]     num_c;
  logic signed [16:0]   den_c;
  logic [VAL_W-1:0]     den_mag;
  logic [7+CNT_W:0]     step_idx;

  // divider step
  logic [VAL_W:0]   rem_sh;
  logic             div_ge;
  logic [VAL_W:0]   rem_sub;

  // final terms
  logic signed [NW:0]   q_s;
  logic signed [PW-1:0] prod_c;
  logic signed [TW-1:0] t_c;
  logic [TEMP_W-1:0]    temp_sat;

  assign in_index   = s_axis_tdata_i[5:0];
  assign in_value   = s_axis_tdata_i[21:6];
  assign in_reading = s_axis_tdata_i[37:22];

  assign cfg_ready_o     = 1'b1;
  assign cfg_fire        = cfg_valid_i & cfg_ready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~out_valid_q | m_axis_tready_i;

  // writes beyond the table depth are dropped
  assign mem_we = s_fire & (s_axis_tuser_i == OP_WRITE) & (32'(in_index) < CURVE_DEPTH);

  // entries in use, clipped to the table depth
  assign len_c = (32'(curve_len_q) > CURVE_DEPTH) ? CNT_W'(CURVE_DEPTH)
                                                  : CNT_W'(curve_len_q);

  // while comparing, fetch the next entry ahead so the scan runs one per cycle
  assign i_nxt   = i_q + 1'b1;
  assign rd_addr = (state_q == ST_CMP) ? i_nxt[ADDR_W-1:0] : i_q[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      curve_mem[ADDR_W'(in_index)] <= in_value;
    end
    rd_data_q <= curve_mem[rd_addr];
  end

  // scan compare: entry zero uses itself stepped by one as its predecessor
  assign cur      = rd_data_q;
  assign prev_eff = (i_q == '0) ? (falling_q ? cur - 1'b1 : cur + 1'b1) : prev_q;
  assign match    = falling_q ? (cur >= reading_q) : (cur <= reading_q);
  assign num_c    = falling_q ? cur - reading_q : reading_q - cur;
  assign den_c    = falling_q ? $signed({1'b0, cur}) - $signed({1'b0, prev_eff})
                              : $signed({1'b0, prev_eff}) - $signed({1'b0, cur});
  assign den_mag  = den_c[16] ? VAL_W'(-den_c) : den_c[VAL_W-1:0];
  assign step_idx = step_q * i_q;

  // restoring divider, one quotient bit per cycle
  assign rem_sh  = {rem_q, quo_q[NW-1]};
  assign div_ge  = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  // quotient takes the sign of the span
  assign q_s    = den_neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign prod_c = $signed({1'b0, step_q}) * q_s;

  // base temperature scaled up, minus the interpolated part, then saturated
  assign t_c = (TW'(base_q) <<< FRAC_BITS) - TW'(prod_q);
  always_comb begin
    if (t_c > SAT_HI) begin
      temp_sat = SAT_HI[TEMP_W-1:0];
    end else if (t_c < SAT_LO) begin
      temp_sat = SAT_LO[TEMP_W-1:0];
    end else begin
      temp_sat = t_c[TEMP_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire && (s_axis_tuser_i == OP_CONVERT)) begin
          i_d     = '0;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = (len_c == '0) ? ST_FIN : ST_CMP;
      end
      ST_CMP: begin
        if (match) begin
          cnt_d   = '0;
          state_d = (den_c == '0) ? ST_MUL : ST_DIV;
        end else begin
          i_d = i_nxt;
          if (i_nxt == len_c) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DCW'(NW - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      temp_min_q  <= 10'sd0;
      temp_max_q  <= 10'sd100;
      step_q      <= 8'd10;
      curve_len_q <= 7'd1;
      falling_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      cnt_q   <= cnt_d;
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_fire) begin
        unique case (cfg_index_i)
          REG_TEMP_MIN:      temp_min_q  <= $signed(cfg_data_i[9:0]);
          REG_TEMP_MAX:      temp_max_q  <= $signed(cfg_data_i[9:0]);
          REG_STEP_DEGREES:  step_q      <= cfg_data_i[7:0];
          REG_CURVE_LENGTH:  curve_len_q <= cfg_data_i[6:0];
          REG_FALLING_CURVE: falling_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        reading_q <= in_reading;
      end
      ST_FETCH: begin
        // result defaults to the beyond value, used for an empty curve or when no entry matches
        base_q   <= BW'(temp_max_q);
        prod_q   <= '0;
        beyond_q <= 1'b1;
        zero_q   <= 1'b0;
      end
      ST_CMP: begin
        prev_q <= cur;
        if (match) begin
          base_q    <= $signed({2'b00, step_idx}) + BW'(temp_min_q);
          beyond_q  <= 1'b0;
          zero_q    <= (den_c == '0);
          den_neg_q <= den_c[16];
          div_q     <= den_mag;
          rem_q     <= '0;
          quo_q     <= (den_c == '0) ? '0 : (NW'(num_c) << FRAC_BITS);
        end
      end
      ST_DIV: begin
        rem_q <= div_ge ? rem_sub[VAL_W-1:0] : rem_sh[VAL_W-1:0];
        quo_q <= {quo_q[NW-2:0], div_ge};
      end
      ST_MUL: begin
        prod_q <= prod_c;
      end
      ST_FIN: begin
        if (out_free) begin
          out_temp_q   <= temp_sat;
          out_beyond_q <= beyond_q;
          out_zero_q   <= zero_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_temp_q;
  assign m_axis_tuser_o  = {out_zero_q, out_beyond_q};

endmodule
